// File: hdl/tcate_pkg.sv
// Shared types and constants for the tick-driven ASCII time emitter.
package tcate_pkg;

   // Configuration register map
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic        CSR_IDX_TICKS_PER_SECOND = 1'b0;
   localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd100;

   // Stream widths
   localparam int unsigned REQ_DATA_WIDTH = 8;
   localparam int unsigned RSP_DATA_WIDTH = 8;

   // Default depth of the snapshot queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // ASCII codes
   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_COLON = 8'd58;
   localparam logic [7:0] ASCII_CR    = 8'd13;

   // Character positions within "hh:mm:ss\r"
   localparam logic [3:0] POS_H_TENS = 4'd0;
   localparam logic [3:0] POS_H_ONES = 4'd1;
   localparam logic [3:0] POS_COLON0 = 4'd2;
   localparam logic [3:0] POS_M_TENS = 4'd3;
   localparam logic [3:0] POS_M_ONES = 4'd4;
   localparam logic [3:0] POS_COLON1 = 4'd5;
   localparam logic [3:0] POS_S_TENS = 4'd6;
   localparam logic [3:0] POS_S_ONES = 4'd7;
   localparam logic [3:0] POS_CR     = 4'd8;

   // Time of day as BCD digits
   typedef struct packed {
      logic [1:0] h_tens;
      logic [3:0] h_ones;
      logic [2:0] m_tens;
      logic [3:0] m_ones;
      logic [2:0] s_tens;
      logic [3:0] s_ones;
   } time_type;

   localparam int unsigned TIME_WIDTH = $bits(time_type);

   // Push side of the snapshot queue
   typedef struct packed {
      logic     valid;
      time_type stamp;
   } push_type;

   // Head of the snapshot queue as seen by the back end
   typedef struct packed {
      logic     avail;
      time_type stamp;
   } head_type;

endpackage

// File: hdl/tcate_front.sv
// Front end: accepts ticks, counts them and keeps the BCD time of day.
module tcate_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   tick_valid,
   input  logic                   tick_bit,
   input  logic                   queue_full,
   input  logic [15:0]            ticks_per_second,
   output logic                   tick_ready,
   output tcate_pkg::push_type    push
);

   logic [15:0]         tick_count_ff, tick_count_in;
   tcate_pkg::time_type time_ff, time_in;
   logic [15:0]         count_inc;
   logic                accept;
   logic                rollover;
   tcate_pkg::time_type advanced;

   assign tick_ready = !queue_full;
   assign accept     = tick_valid && tick_ready && tick_bit;
   assign count_inc  = tick_count_ff + 16'd1;
   assign rollover   = accept && (count_inc == ticks_per_second);

   // Advance the time by one second, wrapping 23:59:59 to 00:00:00
   always_comb begin
      advanced = time_ff;
      if (time_ff.s_ones != 4'd9) begin
         advanced.s_ones = time_ff.s_ones + 4'd1;
      end else begin
         advanced.s_ones = 4'd0;
         if (time_ff.s_tens != 3'd5) begin
            advanced.s_tens = time_ff.s_tens + 3'd1;
         end else begin
            advanced.s_tens = 3'd0;
            if (time_ff.m_ones != 4'd9) begin
               advanced.m_ones = time_ff.m_ones + 4'd1;
            end else begin
               advanced.m_ones = 4'd0;
               if (time_ff.m_tens != 3'd5) begin
                  advanced.m_tens = time_ff.m_tens + 3'd1;
               end else begin
                  advanced.m_tens = 3'd0;
                  if (time_ff.h_tens == 2'd2 && time_ff.h_ones == 4'd3) begin
                     advanced.h_tens = 2'd0;
                     advanced.h_ones = 4'd0;
                  end else if (time_ff.h_ones == 4'd9) begin
                     advanced.h_ones = 4'd0;
                     advanced.h_tens = time_ff.h_tens + 2'd1;
                  end else begin
                     advanced.h_ones = time_ff.h_ones + 4'd1;
                  end
               end
            end
         end
      end
   end

   // Next state of the tick counter and the clock
   always_comb begin
      tick_count_in = tick_count_ff;
      time_in       = time_ff;
      if (rollover) begin
         tick_count_in = 16'd0;
         time_in       = advanced;
      end else if (accept) begin
         tick_count_in = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= 16'd0;
         time_ff       <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         time_ff       <= time_in;
      end
   end

   // Hand the new time to the queue on every rollover
   assign push.valid = rollover;
   assign push.stamp = advanced;

endmodule

// File: hdl/tcate_queue.sv
// Short queue of time snapshots between the front and back ends.
module tcate_queue #(
   parameter int unsigned DEPTH = tcate_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  tcate_pkg::push_type push,
   input  logic                pop,
   output logic                full,
   output tcate_pkg::head_type head
);

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

   tcate_pkg::time_type         entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]        count_ff, count_in;
   logic                        do_push;
   logic                        do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the snapshot; payload needs no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.stamp;
      end
   end

   assign head.avail = (count_ff != '0);
   assign head.stamp = entry_ff[rd_ptr_ff];

endmodule

// File: hdl/tcate_back.sv
// Back end: spells out each snapshot as "hh:mm:ss" and CR, one character a cycle while out_ready is high.
module tcate_back (
   input  logic                clock,
   input  logic                reset,
   input  tcate_pkg::head_type head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_char,
   output logic                out_last
);

   logic [3:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       load;
   logic [7:0] char_sel;

   assign load = head.avail && (!valid_ff || out_ready);
   assign pop  = load && (pos_ff == tcate_pkg::POS_CR);

   // Pick the character at the current position
   always_comb begin
      unique case (pos_ff)
         tcate_pkg::POS_H_TENS: char_sel = tcate_pkg::ASCII_ZERO + {6'd0, head.stamp.h_tens};
         tcate_pkg::POS_H_ONES: char_sel = tcate_pkg::ASCII_ZERO + {4'd0, head.stamp.h_ones};
         tcate_pkg::POS_COLON0: char_sel = tcate_pkg::ASCII_COLON;
         tcate_pkg::POS_M_TENS: char_sel = tcate_pkg::ASCII_ZERO + {5'd0, head.stamp.m_tens};
         tcate_pkg::POS_M_ONES: char_sel = tcate_pkg::ASCII_ZERO + {4'd0, head.stamp.m_ones};
         tcate_pkg::POS_COLON1: char_sel = tcate_pkg::ASCII_COLON;
         tcate_pkg::POS_S_TENS: char_sel = tcate_pkg::ASCII_ZERO + {5'd0, head.stamp.s_tens};
         tcate_pkg::POS_S_ONES: char_sel = tcate_pkg::ASCII_ZERO + {4'd0, head.stamp.s_ones};
         default:               char_sel = tcate_pkg::ASCII_CR;
      endcase
   end

   // Step the position and the output register
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         pos_in   = (pos_ff == tcate_pkg::POS_CR) ? tcate_pkg::POS_H_TENS : pos_ff + 4'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= tcate_pkg::POS_H_TENS;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // Hold the character until the transaction completes
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_sel;
         last_ff <= (pos_ff == tcate_pkg::POS_CR);
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

// File: hdl/tick_clock_ascii_time_emitter.sv
// Top level of the tick-driven clock that emits the time as ASCII text.
// A rollover tick writes the new time into the snapshot queue; the back end then loads the
// first character into its output register, and the nine characters follow at one per cycle
// while rsp_tready stays high. Throughput: one tick per cycle while the snapshot queue has
// room; the back end drains each string through its single character output register.
// Reset clears the tick count, the time (00:00:00) and the queue; ticks_per_second = 100.
module tick_clock_ascii_time_emitter #(
   parameter int unsigned QUEUE_DEPTH = tcate_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Tick stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tcate_pkg::REQ_DATA_WIDTH-1:0] req_tdata,  // [0] tick, [7:1] zero
   // Character stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [tcate_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,  // [7:0] character
   output logic                                 rsp_tlast,
   // Configuration
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tcate_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [tcate_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [tcate_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);

   logic [15:0]         tps_ff, tps_in;
   logic                csr_write;
   logic                csr_hit;
   logic                queue_full;
   logic                pop;
   tcate_pkg::push_type push;
   tcate_pkg::head_type head;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == tcate_pkg::CSR_IDX_TICKS_PER_SECOND);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      tps_in = tps_ff;
      if (csr_write && csr_hit) begin
         tps_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= tcate_pkg::TICKS_PER_SECOND_RESET;
      end else begin
         tps_ff <= tps_in;
      end
   end

   assign csr_prdata = csr_hit ? {16'd0, tps_ff} : '0;

   tcate_front u_front (
      .clock            (clock),
      .reset            (reset),
      .tick_valid       (req_tvalid),
      .tick_bit         (req_tdata[0]),
      .queue_full       (queue_full),
      .ticks_per_second (tps_ff),
      .tick_ready       (req_tready),
      .push             (push)
   );

   tcate_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   tcate_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// File: tb/sv/tb_tick_clock_ascii_time_emitter.sv
// Self-checking testbench for the tick-driven clock that emits hh:mm:ss text.
module tb_tick_clock_ascii_time_emitter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SECONDS_PER_DAY    = 86400;
   localparam int unsigned SECONDS_PER_HOUR   = 3600;
   localparam int unsigned SECONDS_PER_MINUTE = 60;
   localparam int unsigned HOURS_PER_DAY      = 24;
   localparam int unsigned RANDOM_TICKS       = 350;
   localparam int unsigned STALL_LIMIT        = 2000;
   localparam int unsigned REPORT_LINES       = 40;
   localparam int unsigned PLAN_ROWS          = 24;

   localparam logic [tcate_pkg::CSR_ADDR_WIDTH-1:0] CSR_ADDR_RATE   =
      {tcate_pkg::CSR_IDX_TICKS_PER_SECOND, 2'b00};
   localparam logic [tcate_pkg::CSR_ADDR_WIDTH-1:0] CSR_ADDR_UNUSED =
      {~tcate_pkg::CSR_IDX_TICKS_PER_SECOND, 2'b00};
   localparam logic [63:0]                          NO_TEXT         = 64'd0;

   typedef enum logic [1:0] {ROW_TICK, ROW_BLANK, ROW_WRITE, ROW_READ} row_kind_type;

   // One line of the directed plan; shows holds "hh:mm:ss" where the time text is known
   typedef struct packed {
      row_kind_type                         kind;
      logic [tcate_pkg::CSR_ADDR_WIDTH-1:0] addr;
      logic [31:0]                          value;
      logic [63:0]                          shows;
   } plan_row_type;

   typedef struct packed {
      logic [7:0] code;
      logic       ends;
   } text_char_type;

   logic                                 clock       = 1'b0;
   logic                                 reset       = 1'b1;
   logic                                 req_tvalid  = 1'b0;
   logic                                 req_tready;
   logic [tcate_pkg::REQ_DATA_WIDTH-1:0] req_tdata   = '0;  // [0] tick, [7:1] zero
   logic                                 rsp_tvalid;
   logic                                 rsp_tready  = 1'b0;
   logic [tcate_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;         // [7:0] character
   logic                                 rsp_tlast;
   logic                                 csr_psel    = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite  = 1'b0;
   logic [tcate_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [tcate_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [tcate_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                                 csr_pready;

   // Predicted clock state and the characters still owed by the block
   logic [15:0]    rate_setting = tcate_pkg::TICKS_PER_SECOND_RESET;
   logic [15:0]    tick_tally   = '0;
   int unsigned    day_seconds  = 0;
   text_char_type  pending_chars[$];
   logic [63:0]    line_acc     = '0;
   logic [63:0]    shown_time   = '0;

   bit             steady         = 1'b0;
   int unsigned    mismatch_count = 0;
   int unsigned    ticks_taken    = 0;
   int unsigned    blanks_taken   = 0;
   int unsigned    strings_seen   = 0;
   int unsigned    rate_changes   = 0;
   int unsigned    stall_cycles   = 0;
   plan_row_type   plan [0:PLAN_ROWS-1];

   tick_clock_ascii_time_emitter uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LINES) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   function automatic void add_char(input logic [7:0] code, input logic ends);
      pending_chars.push_back('{code, ends});
   endfunction

   function automatic void add_two_digits(input int unsigned v);
      add_char(tcate_pkg::ASCII_ZERO + 8'((v / 10) % 10), 1'b0);
      add_char(tcate_pkg::ASCII_ZERO + 8'(v % 10), 1'b0);
   endfunction

   // Track register writes and ticks, check every character transaction
   always @(posedge clock) begin : monitor
      text_char_type due;
      int unsigned   hh, mm, ss;
      if (reset) begin
         rate_setting = tcate_pkg::TICKS_PER_SECOND_RESET;
         tick_tally   = '0;
         day_seconds  = 0;
         pending_chars.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_chars.size() == 0) begin
               report_mismatch($sformatf("character 0x%02h with no text due", rsp_tdata));
            end else begin
               due = pending_chars.pop_front();
               if (rsp_tdata !== due.code) begin
                  report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                            rsp_tdata, due.code));
               end
               if (rsp_tlast !== due.ends) begin
                  report_mismatch($sformatf("last %b on character 0x%02h, expected %b",
                                            rsp_tlast, due.code, due.ends));
               end
            end
            if (rsp_tlast) begin
               shown_time = line_acc;
               line_acc   = '0;
               strings_seen++;
            end else begin
               line_acc = {line_acc[55:0], rsp_tdata};
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_ADDR_RATE) begin
            rate_setting = csr_pwdata[15:0];
         end
         if (req_tvalid && req_tready) begin
            if (!req_tdata[0]) begin
               blanks_taken++;
            end else begin
               ticks_taken++;
               tick_tally = tick_tally + 16'd1;
               if (tick_tally == rate_setting) begin
                  // Roll the second over and queue the new time as text
                  tick_tally = '0;
                  if (day_seconds >= SECONDS_PER_DAY - 1) begin
                     day_seconds = 0;
                  end else begin
                     day_seconds++;
                  end
                  hh = (day_seconds / SECONDS_PER_HOUR) % HOURS_PER_DAY;
                  mm = (day_seconds % SECONDS_PER_HOUR) / SECONDS_PER_MINUTE;
                  ss = day_seconds % SECONDS_PER_MINUTE;
                  add_two_digits(hh);
                  add_char(tcate_pkg::ASCII_COLON, 1'b0);
                  add_two_digits(mm);
                  add_char(tcate_pkg::ASCII_COLON, 1'b0);
                  add_two_digits(ss);
                  add_char(tcate_pkg::ASCII_CR, 1'b1);
               end
            end
         end
      end
   end

   // Stall the character stream at random, except through steady stretches
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 38);
   end

   // Abort when no transaction of any kind completes for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", stall_cycles);
         $display("FAILED: results differ");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one tick transaction, with random idle cycles ahead of it
   task automatic push_tick(input logic lit);
      while (!steady && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(tcate_pkg::REQ_DATA_WIDTH-1){1'b0}}, lit};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold the tick stream until every owed character has come, then let the block settle
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_chars.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // One register transfer; leaves psel high so that transfers can run back to back
   task automatic csr_access(input logic wr,
                             input logic [tcate_pkg::CSR_ADDR_WIDTH-1:0] addr,
                             input logic [31:0] data, output logic [31:0] got);
      csr_psel   <= 1'b1;
      csr_pwrite <= wr;
      csr_paddr  <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_penable <= 1'b0;
   endtask

   // Write a register, then read the rate back and compare with the tracked value
   task automatic set_rate(input logic [tcate_pkg::CSR_ADDR_WIDTH-1:0] addr,
                           input logic [31:0] data);
      logic [31:0] got;
      csr_access(1'b1, addr, data, got);
      csr_access(1'b0, CSR_ADDR_RATE, 32'd0, got);
      csr_psel <= 1'b0;
      if (got !== {16'd0, rate_setting}) begin
         report_mismatch($sformatf("rate reads %0d, expected %0d", got, rate_setting));
      end
      rate_changes++;
   endtask

   initial begin : stimulus
      int unsigned sent, segment, pick, reps;
      logic        lit;
      logic [31:0] got;

      plan = '{
         '{ROW_READ,  CSR_ADDR_RATE,   32'd100,          NO_TEXT},
         '{ROW_WRITE, CSR_ADDR_RATE,   32'd1,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            "00:00:01"},
         '{ROW_BLANK, CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            "00:00:02"},
         '{ROW_WRITE, CSR_ADDR_RATE,   32'hFFFF_0003,    NO_TEXT},
         '{ROW_READ,  CSR_ADDR_RATE,   32'd3,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_BLANK, CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            "00:00:03"},
         '{ROW_WRITE, CSR_ADDR_UNUSED, 32'd1,            NO_TEXT},
         '{ROW_READ,  CSR_ADDR_RATE,   32'd3,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            "00:00:04"},
         '{ROW_WRITE, CSR_ADDR_RATE,   32'd2,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            "00:00:05"},
         '{ROW_WRITE, CSR_ADDR_RATE,   32'd1,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_BLANK, CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            NO_TEXT},
         '{ROW_TICK,  CSR_ADDR_RATE,   32'd0,            "00:00:08"}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed plan: reset value, small rates, ignored writes, empty ticks
      for (int i = 0; i < PLAN_ROWS; i++) begin
         case (plan[i].kind) inside
            ROW_TICK, ROW_BLANK: begin
               push_tick(plan[i].kind == ROW_TICK);
               if (plan[i].shows != NO_TEXT) begin
                  wait_drained();
                  if (shown_time !== plan[i].shows) begin
                     report_mismatch($sformatf("time text %s, expected %s",
                                               shown_time, plan[i].shows));
                  end
               end
            end
            ROW_WRITE: begin
               wait_drained();
               set_rate(plan[i].addr, plan[i].value);
            end
            default: begin
               wait_drained();
               csr_access(1'b0, plan[i].addr, 32'd0, got);
               csr_psel <= 1'b0;
               if (got !== plan[i].value) begin
                  report_mismatch($sformatf("register reads %0d, expected %0d",
                                            got, plan[i].value));
               end
            end
         endcase
      end

      // Random segments, each at its own small rate; keep the rate above the tally
      sent    = 0;
      segment = 0;
      while (sent < RANDOM_TICKS) begin
         wait_drained();
         if ($urandom_range(3) == 0) begin
            set_rate(CSR_ADDR_UNUSED, $urandom());
            @(posedge clock);
         end
         pick = ($urandom_range(4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         if (pick <= tick_tally) begin
            pick = tick_tally + $urandom_range(1, 4);
         end
         set_rate(CSR_ADDR_RATE, {16'($urandom()), 16'(pick)});
         steady = (segment == 2);
         reps = $urandom_range(20, 60);
         repeat (reps) begin
            if ($urandom_range(49) == 0) begin
               wait_drained();
            end
            lit = ($urandom_range(99) >= 15);
            push_tick(lit);
            sent++;
         end
         segment++;
      end

      wait_drained();
      repeat (16) @(posedge clock);
      $display("Covered %0d ticks and %0d empty transactions over %0d register writes,",
               ticks_taken, blanks_taken, rate_changes);
      $display("checking %0d time strings against the tracked clock.", strings_seen);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
